// ===== hw/rtl/seven_segment_frame_encoder_top_assert.svh =====
// assertion macros for the seven-segment frame encoder checker
// expects clk and arst_n to be visible where a macro is used
`ifndef SEVEN_SEGMENT_FRAME_ENCODER_TOP_ASSERT_SVH
`define SEVEN_SEGMENT_FRAME_ENCODER_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SSFE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define SSFE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/ssfe_pkg.sv =====
// types, font tables and helper functions for the seven-segment frame encoder
// no dependencies
`timescale 1ns / 1ps

package ssfe_pkg;

	localparam int NUM_DIGITS = 8;
	localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);

	localparam logic [1:0] CMD_HEX     = 2'd0;
	localparam logic [1:0] CMD_TEXT    = 2'd1;
	localparam logic [1:0] CMD_ALL_ON  = 2'd2;
	localparam logic [1:0] CMD_DIG_MAP = 2'd3;

	localparam logic [3:0] FIRST_DIGIT_REG = 4'h1;
	localparam logic [7:0] SEG_ALL_ON      = 8'hFF;
	localparam logic [7:0] SEG_BLANK       = 8'h00;
	localparam logic [7:0] KEEP_MASK       = 8'h81;

	localparam logic [7:0] HEX_FONT [16] = '{
		8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70,
		8'h7F, 8'h7B, 8'h77, 8'h1F, 8'h4E, 8'h3D, 8'h4F, 8'h47
	};

	localparam logic [7:0] LETTER_FONT [26] = '{
		8'h77, 8'h1F, 8'h4E, 8'h3D, 8'h4F, 8'h47, 8'h5E, 8'h37, 8'h30, 8'h3C,
		8'h37, 8'h0E, 8'h54, 8'h15, 8'h7E, 8'h67, 8'h73, 8'h05, 8'h5B, 8'h0F,
		8'h3E, 8'h3E, 8'h3E, 8'h37, 8'h3B, 8'h6D
	};

	// lowercase glyphs b d n r t and stand-ins k m v w x
	localparam logic [25:0] INEXACT_LETTERS = 26'h0EA340A;

	localparam logic [7:0] BANNER [4] = '{8'h67, 8'h7E, 8'h5B, 8'h0F};

	localparam logic [DIG_IDX_W-1:0] POS_TO_DIGIT [NUM_DIGITS] = '{
		3'd4, 3'd5, 3'd6, 3'd7, 3'd0, 3'd1, 3'd2, 3'd3
	};

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] post_code;
		logic [63:0] text_chars;
		logic [3:0]  text_length;
	} req_t;

	typedef struct packed {
		logic [3:0] digit_register;
		logic [7:0] segment_value;
		logic       approximate;
		logic       status;
		logic       last;
	} res_t;

	// what one lane found for its display position
	typedef struct packed {
		logic [7:0] seg;
		logic       apx;
		logic       miss;
	} lane_t;

	// whole frame in driver digit order
	typedef struct packed {
		logic [NUM_DIGITS-1:0][7:0] seg;
		logic [NUM_DIGITS-1:0]      apx;
		logic                       err;
	} frame_t;

	function automatic lane_t glyph_lookup(input logic [7:0] c);
		lane_t      g;
		logic [7:0] u;
		logic [4:0] li;
		g  = '0;
		u  = c;
		li = '0;
		if (c >= 8'h61 && c <= 8'h7A) begin
			u = c - 8'h20;
		end
		if (c >= 8'h30 && c <= 8'h39) begin
			g.seg = HEX_FONT[c[3:0]];
		end else if (u >= 8'h41 && u <= 8'h5A) begin
			li    = 5'(u - 8'h41);
			g.seg = LETTER_FONT[li];
			g.apx = INEXACT_LETTERS[li];
		end else begin
			case (c)
				8'h20: g.seg = 8'h00;
				8'h24: begin
					g.seg = LETTER_FONT[18];
					g.apx = 1'b1;
				end
				8'h2D: g.seg = 8'h01;
				8'h5F: g.seg = 8'h08;
				8'h3D: g.seg = 8'h09;
				8'h2E: g.seg = 8'h80;
				8'h3F: g.seg = 8'h65;
				8'h2A: g.seg = 8'h63;
				default: g.miss = 1'b1;
			endcase
		end
		return g;
	endfunction

	// a/d, b/e, c/f exchange for an upside-down display
	function automatic logic [7:0] swap_segments(input logic [7:0] s);
		logic [7:0] r;
		r    = s & KEEP_MASK;
		r[3] = s[6];
		r[6] = s[3];
		r[2] = s[5];
		r[5] = s[2];
		r[1] = s[4];
		r[4] = s[1];
		return r;
	endfunction

endpackage

// ===== hw/rtl/ssfe_lane.sv =====
// one display position: picks and looks up its glyph, registered at stage 1
// depends on ssfe_pkg
`timescale 1ns / 1ps

module ssfe_lane import ssfe_pkg::*; #(
	parameter int LANE = 0
) (
	input  logic  clk,
	input  logic  load,
	input  req_t  req,
	output lane_t lane_s1
);

	lane_t      found;
	lane_t      text_glyph;
	logic       active;
	logic [3:0] nib;

	assign text_glyph = glyph_lookup(req.text_chars[8*LANE +: 8]);
	// lengths above eight cover every lane anyway
	assign active = {1'b0, 3'(LANE)} < req.text_length;
	assign nib = req.post_code[4*(3-(LANE%4)) +: 4];

	always_comb begin
		found = '0;
		case (req.command)
			CMD_HEX: begin
				if (LANE < 4) found.seg = BANNER[LANE%4];
				else          found.seg = HEX_FONT[nib];
			end
			CMD_TEXT: begin
				if (active) found = text_glyph;
				else        found.seg = SEG_BLANK;
			end
			CMD_ALL_ON:  found.seg = SEG_ALL_ON;
			CMD_DIG_MAP: found.seg = HEX_FONT[4'(LANE)];
			default:     found = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			lane_s1 <= found;
		end
	end

endmodule

// ===== hw/rtl/ssfe_merge.sv =====
// merges the lane results into one frame in driver digit order, with rotation
// depends on ssfe_pkg
`timescale 1ns / 1ps

module ssfe_merge import ssfe_pkg::*; (
	input  logic                        rotate,
	input  lane_t [NUM_DIGITS-1:0]      lanes,
	output frame_t                      frame
);

	logic [DIG_IDX_W-1:0] pos;
	logic [DIG_IDX_W-1:0] dig;

	always_comb begin
		frame = '0;
		pos   = '0;
		dig   = '0;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			pos = rotate ? DIG_IDX_W'(NUM_DIGITS - 1 - i) : DIG_IDX_W'(i);
			dig = POS_TO_DIGIT[pos];
			// all-on frames pass unchanged: the scatter and swap are permutations
			frame.seg[dig] = rotate ? swap_segments(lanes[i].seg) : lanes[i].seg;
			frame.apx[dig] = lanes[i].apx;
			frame.err      = frame.err | lanes[i].miss;
		end
	end

endmodule

// ===== hw/rtl/ssfe_serializer.sv =====
// holds a frame; one digit write a cycle leaves via an output register unless stalled
// depends on ssfe_pkg
`timescale 1ns / 1ps

module ssfe_serializer import ssfe_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   frame_valid,
	output logic   frame_ready,
	input  frame_t frame,
	output logic   res_valid,
	input  logic   res_ready,
	output res_t   res
);

	logic [NUM_DIGITS-1:0][7:0] seg_q;
	logic [NUM_DIGITS-1:0]      apx_q;
	logic                       err_q;
	logic                       busy_q;
	logic [DIG_IDX_W-1:0]       idx_q;
	logic                       out_valid_q;
	res_t                       out_q;
	logic                       out_free;
	logic                       emit;
	logic                       emit_last;
	logic                       load;

	assign out_free    = !out_valid_q || res_ready;
	assign emit        = busy_q && out_free;
	assign emit_last   = err_q || (idx_q == DIG_IDX_W'(NUM_DIGITS - 1));
	assign frame_ready = !busy_q || (emit && emit_last);
	assign load        = frame_valid && frame_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit)          out_valid_q <= 1'b1;
			else if (res_ready) out_valid_q <= 1'b0;
			if (load) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (emit) begin
				if (emit_last) busy_q <= 1'b0;
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			seg_q <= frame.seg;
			apx_q <= frame.apx;
			err_q <= frame.err;
		end
		if (emit) begin
			if (err_q) begin
				// unrenderable text: one error write only
				out_q.digit_register <= '0;
				out_q.segment_value  <= '0;
				out_q.approximate    <= 1'b0;
				out_q.status         <= 1'b1;
				out_q.last           <= 1'b1;
			end else begin
				out_q.digit_register <= 4'(idx_q) + FIRST_DIGIT_REG;
				out_q.segment_value  <= seg_q[idx_q];
				out_q.approximate    <= apx_q[idx_q];
				out_q.status         <= 1'b0;
				out_q.last           <= emit_last;
			end
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

// ===== hw/rtl/seven_segment_frame_encoder_top.sv =====
// Seven-segment frame encoder: each request becomes eight digit-register writes,
// delivered one per cycle unless the receiver stalls, in register order 1 to 8,
// or a single error write when a text character has no glyph. Eight lanes look
// up all positions of a request in parallel; the frame then drains through the
// output register. The next request is taken and looked up while the previous
// frame is still going out. From acceptance a request passes the lane registers,
// the serializer frame registers and the output register before its first write.
// rotate_q resets to 1 and is written through cfg.
// depends on ssfe_pkg, ssfe_lane, ssfe_merge, ssfe_serializer
`timescale 1ns / 1ps

module seven_segment_frame_encoder_top import ssfe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic res_valid,
	input  logic res_ready,
	output res_t res,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_data
);

	logic                   rotate_q;
	logic                   valid_s1;
	logic                   req_take;
	logic                   frame_ready;
	lane_t [NUM_DIGITS-1:0] lanes_s1;
	frame_t                 frame;

	assign cfg_ready = 1'b1;
	assign req_take  = req_valid && req_ready;
	assign req_ready = !valid_s1 || frame_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotate_q <= 1'b1;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) rotate_q <= cfg_data;
			if (req_take)         valid_s1 <= 1'b1;
			else if (frame_ready) valid_s1 <= 1'b0;
		end
	end

	for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_lane
		ssfe_lane #(
			.LANE(g)
		) u_lane (
			.clk     (clk),
			.load    (req_take),
			.req     (req),
			.lane_s1 (lanes_s1[g])
		);
	end

	ssfe_merge u_merge (
		.rotate (rotate_q),
		.lanes  (lanes_s1),
		.frame  (frame)
	);

	ssfe_serializer u_ser (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (valid_s1),
		.frame_ready (frame_ready),
		.frame       (frame),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

endmodule

// ===== hw/rtl/ssfe_checker.sv =====
// port-level checks on the result channel of the frame encoder, bound to the top
// depends on ssfe_pkg and seven_segment_frame_encoder_top_assert.svh
`timescale 1ns / 1ps
`include "seven_segment_frame_encoder_top_assert.svh"

module ssfe_checker import ssfe_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input res_t res
);

	// a stalled result holds
	`SSFE_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res), "result changed while stalled")

	// error write is the whole response
	`SSFE_ASSERT_NOW(a_err_shape, res_valid && res.status, res.last && res.digit_register == 4'd0 && res.segment_value == 8'd0 && !res.approximate, "malformed error result")

	// ok writes never go to register 0, and the write to register 8 alone closes the request
	`SSFE_ASSERT_NOW(a_last_on_eight, res_valid && !res.status, res.digit_register != 4'd0 && (res.last == (res.digit_register == 4'd8)), "last flag out of place")

	// after a non-final ok write the next write goes to the following register
	`SSFE_ASSERT_NEXT(a_reg_order, res_valid && res_ready && !res.status && !res.last, !res_valid || res.digit_register == $past(res.digit_register) + 4'd1, "digit registers out of order")

endmodule

bind seven_segment_frame_encoder_top ssfe_checker u_ssfe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);

// ===== tb/seven_segment_frame_encoder_checker.sv =====
// scoreboard for the seven-segment frame encoder: watches the request, result and cfg channels,
// predicts every digit-register write and compares in order
// depends on ssfe_pkg for the channel types and command codes
`timescale 1ns / 1ps

module seven_segment_frame_encoder_checker import ssfe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req,
	input  logic res_valid,
	input  logic res_ready,
	input  res_t res,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic cfg_data,
	output int   fail_count,
	output int   pending,
	output int   frames_seen,
	output int   glyph_errors,
	output int   writes_checked
);

	typedef struct packed {
		logic [7:0] seg;
		logic       apx;
		logic       bad;
	} glyph_t;

	localparam logic [7:0] HEX_SEGS [16] = '{
		8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70,
		8'h7F, 8'h7B, 8'h77, 8'h1F, 8'h4E, 8'h3D, 8'h4F, 8'h47
	};

	localparam logic [7:0] ALPHA_SEGS [26] = '{
		8'h77, 8'h1F, 8'h4E, 8'h3D, 8'h4F, 8'h47, 8'h5E, 8'h37, 8'h30, 8'h3C,
		8'h37, 8'h0E, 8'h54, 8'h15, 8'h7E, 8'h67, 8'h73, 8'h05, 8'h5B, 8'h0F,
		8'h3E, 8'h3E, 8'h3E, 8'h37, 8'h3B, 8'h6D
	};

	localparam logic [7:0] POST_WORD [4] = '{8'h67, 8'h7E, 8'h5B, 8'h0F};

	res_t writes_due [$];
	logic rotate_on = 1'b1;

	initial begin
		fail_count     = 0;
		pending        = 0;
		frames_seen    = 0;
		glyph_errors   = 0;
		writes_checked = 0;
	end

	function automatic glyph_t render_char(input logic [7:0] c);
		glyph_t     g;
		logic [7:0] up;
		g  = '0;
		up = (c >= "a" && c <= "z") ? c - 8'd32 : c;
		if (c >= "0" && c <= "9") begin
			g.seg = HEX_SEGS[int'(c) - 48];
		end else if (up >= "A" && up <= "Z") begin
			g.seg = ALPHA_SEGS[int'(up) - 65];
			// lowercase shapes and stand-ins
			case (up)
				"B", "D", "N", "R", "T", "K", "M", "V", "W", "X": g.apx = 1'b1;
				default: g.apx = 1'b0;
			endcase
		end else begin
			case (c)
				" ": g.seg = 8'h00;
				"$": begin
					g.seg = ALPHA_SEGS[18];
					g.apx = 1'b1;
				end
				"-": g.seg = 8'h01;
				"_": g.seg = 8'h08;
				"=": g.seg = 8'h09;
				".": g.seg = 8'h80;
				"?": g.seg = 8'h65;
				"*": g.seg = 8'h63;
				default: g.bad = 1'b1;
			endcase
		end
		return g;
	endfunction

	// a<->d, b<->e, c<->f, dp and g stay
	function automatic logic [7:0] flip_segments(input logic [7:0] s);
		return {s[7], s[3], s[2], s[1], s[6], s[5], s[4], s[0]};
	endfunction

	function automatic void queue_frame(input req_t r);
		logic [7:0] pos_seg [8];
		logic       pos_apx [8];
		logic [7:0] dig_seg [8];
		logic       dig_apx [8];
		glyph_t     g;
		res_t       w;
		int         len;
		int         p;
		int         d;
		frames_seen = frames_seen + 1;
		for (int i = 0; i < 8; i++) begin
			pos_seg[i] = 8'h00;
			pos_apx[i] = 1'b0;
		end
		case (r.command)
			CMD_HEX: begin
				for (int i = 0; i < 4; i++) begin
					pos_seg[i]     = POST_WORD[i];
					pos_seg[i + 4] = HEX_SEGS[4'(r.post_code >> (12 - 4 * i))];
				end
			end
			CMD_TEXT: begin
				len = (r.text_length > 4'd8) ? 8 : int'(r.text_length);
				for (int i = 0; i < len; i++) begin
					g = render_char(r.text_chars[8 * i +: 8]);
					if (g.bad) begin
						w = '0;
						w.status = 1'b1;
						w.last   = 1'b1;
						writes_due.push_back(w);
						glyph_errors = glyph_errors + 1;
						return;
					end
					pos_seg[i] = g.seg;
					pos_apx[i] = g.apx;
				end
			end
			CMD_DIG_MAP: begin
				for (int i = 0; i < 8; i++) begin
					pos_seg[i] = HEX_SEGS[i];
				end
			end
			default: ;
		endcase
		for (int i = 0; i < 8; i++) begin
			if (r.command == CMD_ALL_ON) begin
				dig_seg[i] = 8'hFF;
				dig_apx[i] = 1'b0;
			end else begin
				p = rotate_on ? 7 - i : i;
				d = (p + 4) % 8;
				dig_seg[d] = rotate_on ? flip_segments(pos_seg[i]) : pos_seg[i];
				dig_apx[d] = pos_apx[i];
			end
		end
		for (int i = 0; i < 8; i++) begin
			w.digit_register = 4'(i + 1);
			w.segment_value  = dig_seg[i];
			w.approximate    = dig_apx[i];
			w.status         = 1'b0;
			w.last           = (i == 7);
			writes_due.push_back(w);
		end
	endfunction

	function automatic void flag(input string msg);
		fail_count = fail_count + 1;
		if (fail_count <= 10) begin
			$display("%0t: %s", $realtime, msg);
		end
	endfunction

	always @(posedge clk) begin : watch
		res_t want;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				writes_checked = writes_checked + 1;
				if (writes_due.size() == 0) begin
					flag($sformatf("unexpected write: reg %0d seg %02h apx %0b st %0b last %0b",
						res.digit_register, res.segment_value, res.approximate, res.status,
						res.last));
				end else begin
					want = writes_due.pop_front();
					if (res.digit_register !== want.digit_register ||
							res.segment_value !== want.segment_value ||
							res.approximate !== want.approximate ||
							res.status !== want.status || res.last !== want.last) begin
						flag($sformatf({"write mismatch: expected reg %0d seg %02h apx %0b st %0b ",
							"last %0b, got reg %0d seg %02h apx %0b st %0b last %0b"},
							want.digit_register, want.segment_value, want.approximate,
							want.status, want.last, res.digit_register, res.segment_value,
							res.approximate, res.status, res.last));
					end
				end
			end
			if (req_valid && req_ready) begin
				queue_frame(req);
			end
			if (cfg_valid && cfg_ready) begin
				rotate_on = cfg_data;
			end
			pending = writes_due.size();
		end
	end

endmodule

// ===== tb/tb_seven_segment_frame_encoder_top.sv =====
// testbench top for the seven-segment frame encoder: clock, reset, request and cfg stimulus,
// receiver stalls and the verdict
// depends on ssfe_pkg, seven_segment_frame_encoder_top and seven_segment_frame_encoder_checker
`timescale 1ns / 1ps

module tb_seven_segment_frame_encoder_top;
	import ssfe_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 45;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic res_valid;
	logic res_ready;
	res_t res;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_data;

	int   fail_count;
	int   pending;
	int   frames_seen;
	int   glyph_errors;
	int   writes_checked;
	int   cycles;
	int   tx_idle_pct  = 0;
	int   rx_stall_pct = 0;
	logic hold_go      = 1'b0;
	logic hold_over    = 1'b0;

	string glyph_chars =
		"0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz $-_=.?*";

	seven_segment_frame_encoder_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	seven_segment_frame_encoder_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.req            (req),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.res            (res),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.pending        (pending),
		.frames_seen    (frames_seen),
		.glyph_errors   (glyph_errors),
		.writes_checked (writes_checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	// long receiver hold-off, counted here once the stimulus asks for it
	initial begin
		wait (hold_go);
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_over = 1'b1;
	end

	always @(negedge clk) begin
		res_ready <= !(hold_go && !hold_over) && ($urandom_range(0, 99) >= rx_stall_pct);
	end

	function automatic req_t text_req(input string s, input int n);
		req_t r;
		r             = '0;
		r.command     = CMD_TEXT;
		r.post_code   = 16'($urandom);
		r.text_length = 4'(n);
		for (int i = 0; i < s.len() && i < 8; i++) begin
			r.text_chars[8 * i +: 8] = s[i];
		end
		return r;
	endfunction

	function automatic req_t plain_req(input logic [1:0] cmd, input logic [15:0] code);
		req_t r;
		r.command     = cmd;
		r.post_code   = code;
		r.text_chars  = {$urandom, $urandom};
		r.text_length = 4'($urandom);
		return r;
	endfunction

	// mostly well-formed text, some raw bytes, planted bad glyphs and overlong lengths
	function automatic req_t random_request();
		req_t r;
		int   kind;
		kind          = $urandom_range(0, 9);
		r.command     = ($urandom_range(0, 9) < 5) ? CMD_TEXT : 2'($urandom_range(0, 3));
		r.post_code   = 16'($urandom);
		r.text_length = 4'($urandom_range(0, 8));
		for (int i = 0; i < 8; i++) begin
			r.text_chars[8 * i +: 8] = glyph_chars[$urandom_range(0, glyph_chars.len() - 1)];
		end
		if (kind == 7) begin
			r.text_chars = {$urandom, $urandom};
		end else if (kind == 8) begin
			r.text_chars[8 * $urandom_range(0, 7) +: 8] = 8'($urandom);
		end else if (kind == 9) begin
			r.text_length = 4'($urandom_range(9, 15));
		end
		return r;
	endfunction

	// entered just after a falling edge, leaves just after one
	task automatic offer(input req_t r);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
	endtask

	task automatic set_rotate(input logic v);
		req_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic directed_requests();
		req_t r;
		offer(plain_req(CMD_HEX, 16'h0000));
		offer(plain_req(CMD_HEX, 16'hFFFF));
		offer(plain_req(CMD_HEX, 16'hA5C3));
		offer(plain_req(CMD_ALL_ON, 16'($urandom)));
		offer(plain_req(CMD_DIG_MAP, 16'($urandom)));
		offer(text_req("POSt 123", 8));
		offer(text_req("bdnrtkmv", 8));
		offer(text_req("WX$-_=.?", 8));
		offer(text_req("*Az09", 5));
		// overlong length clamps to eight
		offer(text_req("HELLO 42", 15));
		// empty text ignores junk bytes
		r = text_req("", 0);
		r.text_chars = '1;
		offer(r);
		// nul in first position
		offer(text_req("", 1));
		r = text_req("ABCDEFG", 8);
		r.text_chars[63:56] = 8'h80;
		offer(r);
		r = text_req("12345678", 8);
		r.text_chars[31:24] = 8'hFF;
		offer(r);
		// bad byte past the end of the text is fine
		r = text_req("abc", 3);
		r.text_chars[39:32] = 8'h01;
		offer(r);
		offer(text_req("@", 1));
		offer(text_req("{", 1));
		offer(text_req("`[", 2));
		offer(text_req("/:", 2));
		offer(text_req("Zz", 2));
	endtask

	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		cfg_valid = 1'b0;
		cfg_data  = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed_requests();

		// idle mix per phase: none, sender, receiver, both
		for (int phase = 0; phase < 4; phase++) begin
			set_rotate(phase[0]);
			tx_idle_pct  = (phase == 1) ? 85 : (phase == 3) ? 32 : 0;
			rx_stall_pct <= (phase == 2) ? 85 : (phase == 3) ? 32 : 0;
			repeat (PHASE_ITEMS) offer(random_request());
		end

		// receiver holds off while requests keep coming
		set_rotate(1'b0);
		tx_idle_pct  = 0;
		rx_stall_pct <= 0;
		hold_go      <= 1'b1;
		repeat (30) offer(random_request());

		req_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);

		$display("covered %0d requests (%0d with a missing glyph), %0d digit writes checked",
			frames_seen, glyph_errors, writes_checked);
		$display("rotation on and off, four idle mixes and a long receiver hold-off");
		if (fail_count == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
